@@ design/crbd_pkg.sv @@
// Shared types and constants for the channel signal-strength baseline detector.
// No dependencies; every other design file but crbd_ram imports this package.

package crbd_pkg;

	localparam int CMD_W     = 3;
	localparam int CHAN_W    = 6;
	localparam int RSSI_W    = 8;
	localparam int KIND_W    = 2;
	localparam int MODE_W    = 2;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;
	localparam int SUM_W     = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [RSSI_W-1:0] FLIP_MASK = 8'h80;

	localparam logic [CMD_W-1:0] CMD_SETUP = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CAL   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MEAS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	localparam logic [KIND_W-1:0] KIND_REPORT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READBACK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CAL_DONE = 2'd2;

	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ALL    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_THRESH = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_SCAN_MODE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_CAL_COUNT = 2'd2;

	typedef enum logic [2:0] {
		OP_SETUP,
		OP_CAL,
		OP_MEAS,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [CHAN_W-1:0]  channel;
		logic [RSSI_W-1:0]  reading;
	} item_t;

endpackage

@@ design/crbd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.

module crbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/crbd_front.sv @@
// Input side: accepts stream transactions, converts the reading and sorts each
// command into a queue operation or drops it. Depends on crbd_pkg.

module crbd_front
	import crbd_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,
	input  logic        full,
	output logic        push,
	output item_t       item
);

	logic [CMD_W-1:0]  cmd;
	logic [CHAN_W-1:0] channel;
	logic              in_range;
	logic              keep;

	assign cmd      = s_tdata[CMD_W-1:0];
	assign channel  = s_tdata[CMD_W+CHAN_W-1:CMD_W];
	assign in_range = (32'(channel) < 32'(CHANNELS));
	assign s_tready = !full;

	always_comb begin
		item.channel = channel;
		item.reading = s_tdata[CMD_W+CHAN_W+RSSI_W-1:CMD_W+CHAN_W] ^ FLIP_MASK;
		item.op      = OP_SETUP;
		keep         = 1'b0;
		unique case (cmd)
			CMD_SETUP: begin
				item.op = OP_SETUP;
				keep    = in_range;
			end
			CMD_CAL: begin
				item.op = OP_CAL;
				keep    = in_range;
			end
			CMD_MEAS: begin
				item.op = OP_MEAS;
				keep    = in_range;
			end
			CMD_CLEAR: begin
				item.op = OP_CLEAR;
				keep    = 1'b1;
			end
			CMD_READ: begin
				item.op = OP_READ;
				keep    = in_range;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = s_tvalid && s_tready && keep;

endmodule

@@ design/crbd_fifo.sv @@
// Short operation queue between the input side and the execution side.
// Depends on crbd_pkg.

module crbd_fifo
	import crbd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output item_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/crbd_div.sv @@
// Serial restoring divider, 16-bit dividend by 8-bit divisor, one quotient bit
// per cycle. Depends on crbd_pkg.

module crbd_div
	import crbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [7:0]        divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(SUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [7:0]       rem_q;
	logic [7:0]       div_q;
	logic [8:0]       trial;
	logic             fits;

	assign trial    = {rem_q, quo_q[SUM_W-1]};
	assign fits     = (trial >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? 8'(trial - {1'b0, div_q}) : trial[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(SUM_W-1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SUM_W-1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ design/crbd_back.sv @@
// Execution side: pops queued operations, keeps valid marks, calibration state
// and the baseline RAM, and drives the output register. Depends on crbd_pkg,
// crbd_ram and crbd_div.

module crbd_back
	import crbd_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             head,
	input  logic              empty,
	output logic              pop,
	input  logic [MODE_W-1:0] scan_mode,
	input  logic [7:0]        excess_threshold,
	input  logic [7:0]        cal_count,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [KIND_W-1:0] m_kind,
	output logic [CHAN_W-1:0] m_channel,
	output logic [RSSI_W-1:0] m_value
);

	localparam int CH_W = $clog2(CHANNELS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t              state_q;
	item_t               cur_q;
	logic [CHANNELS-1:0] valid_q;
	logic [SUM_W-1:0]    cal_sum_q;
	logic [7:0]          cal_samples_q;
	logic [CHAN_W-1:0]   cal_channel_q;
	logic [KIND_W-1:0]   res_kind_q;
	logic [RSSI_W-1:0]   res_value_q;
	logic                m_tvalid_q;
	logic [KIND_W-1:0]   m_kind_q;
	logic [CHAN_W-1:0]   m_channel_q;
	logic [RSSI_W-1:0]   m_value_q;

	logic [CH_W-1:0]   head_idx;
	logic [CH_W-1:0]   cur_idx;
	logic              ram_we;
	logic [CH_W-1:0]   ram_waddr;
	logic [RSSI_W-1:0] ram_wdata;
	logic [RSSI_W-1:0] ram_rdata;
	logic [7:0]        need;
	logic              restart;
	logic [SUM_W-1:0]  new_sum;
	logic [7:0]        new_samples;
	logic              finish;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;
	logic [RSSI_W-1:0] avg;
	logic              out_free;
	logic              mode_reports;
	logic              above;

	assign head_idx = CH_W'(head.channel);
	assign cur_idx  = CH_W'(cur_q.channel);
	assign pop      = (state_q == ST_IDLE) && !empty;
	assign out_free = !m_tvalid_q || m_tready;

	assign need        = (cal_count == '0) ? 8'd1 : cal_count;
	assign restart     = (cal_samples_q == '0) || (cal_channel_q != head.channel);
	assign new_sum     = (restart ? '0 : cal_sum_q) + SUM_W'(head.reading);
	assign new_samples = (restart ? '0 : cal_samples_q) + 8'd1;
	assign finish      = (new_samples >= need);
	assign div_start   = pop && (head.op == OP_CAL) && finish;
	assign avg         = (div_quo[SUM_W-1:RSSI_W] != '0) ? 8'hFF : div_quo[RSSI_W-1:0];

	assign mode_reports = (scan_mode == MODE_ALL) || (scan_mode == MODE_THRESH);
	assign above        = ({1'b0, cur_q.reading} >
		({1'b0, ram_rdata} + {1'b0, excess_threshold}));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = head_idx;
		ram_wdata = head.reading;
		if (pop && (head.op == OP_SETUP)) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_DIV) && div_done) begin
			ram_we    = 1'b1;
			ram_waddr = cur_idx;
			ram_wdata = avg;
		end
	end

	crbd_ram #(
		.WIDTH (RSSI_W),
		.DEPTH (CHANNELS)
	) u_baseline_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_idx),
		.rdata (ram_rdata)
	);

	crbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_sum),
		.divisor  (new_samples),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if ((state_q == ST_READ) && (cur_q.op == OP_READ)) begin
			res_kind_q  <= KIND_READBACK;
			res_value_q <= ram_rdata;
		end else if (state_q == ST_READ) begin
			res_kind_q  <= KIND_REPORT;
			res_value_q <= cur_q.reading;
		end else if ((state_q == ST_DIV) && div_done) begin
			res_kind_q  <= KIND_CAL_DONE;
			res_value_q <= avg;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			m_kind_q    <= res_kind_q;
			m_channel_q <= cur_q.channel;
			m_value_q   <= res_value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			cal_sum_q     <= '0;
			cal_samples_q <= '0;
			cal_channel_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						unique case (head.op)
							OP_SETUP: begin
								valid_q[head_idx] <= 1'b1;
							end
							OP_CLEAR: begin
								valid_q <= '0;
							end
							OP_CAL: begin
								cal_channel_q <= head.channel;
								if (finish) begin
									cal_sum_q     <= '0;
									cal_samples_q <= '0;
									state_q       <= ST_DIV;
								end else begin
									cal_sum_q     <= new_sum;
									cal_samples_q <= new_samples;
								end
							end
							OP_MEAS: begin
								if (valid_q[head_idx] && mode_reports) begin
									state_q <= ST_READ;
								end
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					if ((cur_q.op == OP_READ) || (scan_mode == MODE_ALL) || above) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid  = m_tvalid_q;
	assign m_kind    = m_kind_q;
	assign m_channel = m_channel_q;
	assign m_value   = m_value_q;

endmodule

@@ design/channel_rssi_baseline_detector_top.sv @@
// Top level of the per-channel signal-strength baseline detector: configuration
// registers, input decoder, operation queue and execution side.
// Depends on crbd_pkg, crbd_front, crbd_fifo and crbd_back.

// The block takes one command transaction per cycle while its two-entry
// operation queue has room. The execution side handles setup, clear,
// calibration samples that do not finish a run and measurements that
// cannot be reported in its idle state as it pops them; a threshold
// measurement that stays below the limit adds a baseline RAM read, and a
// reported measurement or a readback goes through queue pop, baseline RAM
// read and result load. The sample that finishes a calibration run also
// waits on the 16-step serial divider that forms the average. A result load
// waits while the output register still holds an unaccepted result. Results
// leave through an output register, so a waiting result does not stop the
// next operation from starting. The baseline RAM is not cleared; reading a
// channel whose baseline was never set returns an unspecified value.

module channel_rssi_baseline_detector_top
	import crbd_pkg::*;
#(
	parameter int CHANNELS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,   // cmd[2:0], channel[8:3], raw_rssi[16:9], zero pad
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // channel_out[5:0], value[13:6], zero pad
	output logic [KIND_W-1:0]     m_tuser    // kind[1:0]
);

	logic [MODE_W-1:0] scan_mode_q;
	logic [7:0]        excess_threshold_q;
	logic [7:0]        cal_count_q;
	logic              full;
	logic              empty;
	logic              push;
	logic              pop;
	item_t             push_item;
	item_t             head;
	logic [CHAN_W-1:0] out_channel;
	logic [RSSI_W-1:0] out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_mode_q        <= MODE_OFF;
			excess_threshold_q <= '0;
			cal_count_q        <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SCAN_MODE: scan_mode_q        <= cfg_data[MODE_W-1:0];
				REG_THRESHOLD: excess_threshold_q <= cfg_data;
				REG_CAL_COUNT: cal_count_q        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	crbd_front #(
		.CHANNELS (CHANNELS)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.full     (full),
		.push     (push),
		.item     (push_item)
	);

	crbd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	crbd_back #(
		.CHANNELS (CHANNELS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.empty            (empty),
		.pop              (pop),
		.scan_mode        (scan_mode_q),
		.excess_threshold (excess_threshold_q),
		.cal_count        (cal_count_q),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_kind           (m_tuser),
		.m_channel        (out_channel),
		.m_value          (out_value)
	);

	assign m_tdata = {2'b00, out_value, out_channel};

endmodule

@@ test/channel_rssi_baseline_detector_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for channel_rssi_baseline_detector_top: commands are queued,
// driven on the input stream and predicted on acceptance; results are checked in order.
// Depends on crbd_pkg and the design files of the detector.

module channel_rssi_baseline_detector_top_tb
	import crbd_pkg::*;
;

	localparam int NCHAN = 64;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 40;
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef enum {PACE_FULL, PACE_SENDER_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [CHAN_W-1:0] channel;
		logic [RSSI_W-1:0] raw;
	} command_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAN_W-1:0] channel;
		logic [RSSI_W-1:0] value;
	} result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [15:0]           m_tdata;
	logic [KIND_W-1:0]     m_tuser;

	channel_rssi_baseline_detector_top #(.CHANNELS(NCHAN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// Predicted detector state and register copies.
	logic [RSSI_W-1:0] base_mem [NCHAN];
	logic [NCHAN-1:0]  chan_valid;
	logic [SUM_W-1:0]  acc_sum;
	logic [7:0]        acc_n;
	logic [CHAN_W-1:0] acc_chan;
	logic [MODE_W-1:0] cfg_mode;
	logic [7:0]        cfg_margin;
	logic [7:0]        cfg_avg_n;

	// Stimulus-side knowledge used to shape traffic.
	bit [NCHAN-1:0] gen_written;
	int             gen_base [NCHAN];
	int             chan_pool [8];

	command_t cmd_queue [$];
	result_t  expected_results [$];
	command_t next_cmd;
	result_t  got;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int accepted_count = 0;
	int results_checked = 0;
	int cal_done_count = 0;
	int report_count = 0;
	int phase_count = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic predict_command(input command_t c);
		logic [RSSI_W-1:0] level;
		logic [7:0]        need;
		logic [SUM_W-1:0]  avg;
		level = c.raw ^ FLIP_MASK;
		case (c.cmd)
			CMD_CLEAR: chan_valid = '0;
			CMD_SETUP: begin
				chan_valid[c.channel] = 1'b1;
				base_mem[c.channel] = level;
			end
			CMD_CAL: begin
				need = (cfg_avg_n == 8'd0) ? 8'd1 : cfg_avg_n;
				if (acc_n == 8'd0 || acc_chan != c.channel) begin
					acc_chan = c.channel;
					acc_sum = '0;
					acc_n = 8'd0;
				end
				acc_sum = acc_sum + SUM_W'(level);
				acc_n = acc_n + 8'd1;
				if (acc_n >= need) begin
					avg = acc_sum / SUM_W'(acc_n);
					base_mem[c.channel] = avg[RSSI_W-1:0];
					acc_sum = '0;
					acc_n = 8'd0;
					expected_results.push_back('{KIND_CAL_DONE, c.channel, avg[RSSI_W-1:0]});
					cal_done_count++;
				end
			end
			CMD_MEAS: begin
				if (chan_valid[c.channel] && (cfg_mode == MODE_ALL || (cfg_mode == MODE_THRESH &&
						{1'b0, level} > {1'b0, base_mem[c.channel]} + {1'b0, cfg_margin}))) begin
					expected_results.push_back('{KIND_REPORT, c.channel, level});
					report_count++;
				end
			end
			CMD_READ: expected_results.push_back('{KIND_READBACK, c.channel, base_mem[c.channel]});
			default: ;
		endcase
	endtask

	task automatic check_result(input result_t r);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result kind %0d channel %0d value %0d",
				r.kind, r.channel, r.value));
			return;
		end
		want = expected_results.pop_front();
		if (r.kind != want.kind)
			report_mismatch($sformatf("kind %0d, expected %0d (channel %0d)",
				r.kind, want.kind, want.channel));
		if (r.channel != want.channel)
			report_mismatch($sformatf("channel %0d, expected %0d", r.channel, want.channel));
		if (r.value != want.value)
			report_mismatch($sformatf("value %0d, expected %0d (channel %0d kind %0d)",
				r.value, want.value, want.channel, want.kind));
		results_checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_cmd = cmd_queue.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'd0, next_cmd.raw, next_cmd.channel, next_cmd.cmd};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			predict_command('{s_tdata[2:0], s_tdata[8:3], s_tdata[16:9]});
			accepted_count++;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				got = '{m_tuser, m_tdata[5:0], m_tdata[13:6]};
				check_result(got);
			end
		end
	end

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int ch, input int raw);
		command_t c;
		c.cmd = cmd;
		c.channel = CHAN_W'(ch);
		c.raw = RSSI_W'(raw);
		cmd_queue.push_back(c);
		if (cmd == CMD_SETUP) begin
			gen_written[c.channel] = 1'b1;
			gen_base[c.channel] = int'(c.raw ^ FLIP_MASK);
		end
	endtask

	// Levels of a calibration run: all lowest, all highest, or random.
	task automatic queue_cal_run(input int ch, input int count, input int need);
		int style;
		int lvl;
		int total;
		style = $urandom_range(3);
		total = 0;
		for (int i = 0; i < count; i++) begin
			lvl = (style == 0) ? 0 : (style == 1) ? 255 : $urandom_range(255);
			total += lvl;
			queue_cmd(CMD_CAL, ch, lvl ^ FLIP_MASK);
		end
		if (count >= need) begin
			gen_written[ch] = 1'b1;
			gen_base[ch] = total / count;
		end
	endtask

	function automatic int pick_channel();
		if ($urandom_range(3) != 0)
			return chan_pool[$urandom_range(7)];
		return $urandom_range(NCHAN - 1);
	endfunction

	function automatic int near_threshold(input int ch);
		int lvl;
		lvl = gen_base[ch] + cfg_margin + $urandom_range(4) - 2;
		if (lvl < 0)
			lvl = 0;
		if (lvl > 255)
			lvl = 255;
		return lvl;
	endfunction

	// Mostly well-formed traffic on a few channels, plus broken calibration runs and noise.
	task automatic queue_random_traffic(input int n_items);
		int left;
		int pick;
		int ch;
		int lvl;
		int need;
		int k;
		left = n_items;
		need = (cfg_avg_n == 8'd0) ? 1 : cfg_avg_n;
		while (left > 0) begin
			pick = $urandom_range(99);
			ch = pick_channel();
			if (pick < 20) begin
				queue_cmd(CMD_SETUP, ch, $urandom_range(255));
				left--;
			end else if (pick < 45) begin
				lvl = ($urandom_range(1) == 0) ? near_threshold(ch) : $urandom_range(255);
				queue_cmd(CMD_MEAS, ch, lvl ^ FLIP_MASK);
				left--;
			end else if (pick < 62 && need <= 16) begin
				queue_cal_run(ch, need, need);
				left -= (need < left) ? need : left;
			end else if (pick < 70) begin
				k = (need > 8) ? $urandom_range(8, 1) : (need > 1) ? $urandom_range(need - 1, 1) : 1;
				queue_cal_run(ch, k, need);
				left -= (k < left) ? k : left;
			end else if (pick < 84) begin
				if (!gen_written[ch]) begin
					queue_cmd(CMD_SETUP, ch, $urandom_range(255));
					left--;
				end
				queue_cmd(CMD_READ, ch, $urandom_range(255));
				left--;
			end else if (pick < 89) begin
				queue_cmd(CMD_CLEAR, $urandom_range(NCHAN - 1), $urandom_range(255));
				left--;
			end else begin
				queue_cmd(CMD_W'($urandom_range(7, CMD_READ + 1)), $urandom_range(NCHAN - 1),
					$urandom_range(255));
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_SCAN_MODE: cfg_mode = val[MODE_W-1:0];
			REG_THRESHOLD: cfg_margin = val;
			REG_CAL_COUNT: cfg_avg_n = val;
			default: ;
		endcase
	endtask

	task automatic start_phase(input logic [MODE_W-1:0] mode, input int margin, input int avg_n,
			input pace_t pace);
		wait_drained();
		write_reg(REG_SCAN_MODE, CFG_DATA_W'(mode));
		write_reg(REG_THRESHOLD, CFG_DATA_W'(margin));
		write_reg(REG_CAL_COUNT, CFG_DATA_W'(avg_n));
		@(posedge clk);
		cfg_we <= 1'b0;
		send_idle_pct = (pace == PACE_SENDER_GAPS) ? 78 : (pace == PACE_BOTH) ? 33 : 0;
		stall_pct = (pace == PACE_SINK_STALLS) ? 78 : (pace == PACE_BOTH) ? 33 : 0;
		chan_pool[0] = 0;
		chan_pool[1] = NCHAN - 1;
		for (int i = 2; i < 8; i++)
			chan_pool[i] = $urandom_range(NCHAN - 1);
		phase_count++;
	endtask

	initial begin
		for (int i = 0; i < NCHAN; i++) begin
			base_mem[i] = '0;
			gen_base[i] = 0;
		end
		chan_valid = '0;
		gen_written = '0;
		acc_sum = '0;
		acc_n = 8'd0;
		acc_chan = '0;
		cfg_mode = MODE_OFF;
		cfg_margin = 8'd0;
		cfg_avg_n = 8'd1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Field extremes, every command, unused commands and clearing of valid marks.
		start_phase(MODE_ALL, 0, 1, PACE_FULL);
		queue_cmd(CMD_SETUP, 0, 8'h00);
		queue_cmd(CMD_SETUP, NCHAN - 1, 8'hff);
		queue_cmd(CMD_SETUP, 5, 8'h80);
		queue_cmd(CMD_MEAS, 0, 8'h7f);
		queue_cmd(CMD_MEAS, NCHAN - 1, 8'h80);
		queue_cmd(CMD_MEAS, 5, 8'h00);
		queue_cmd(CMD_MEAS, 10, 8'hff);
		queue_cmd(CMD_CAL, 10, 8'h12);
		queue_cmd(CMD_READ, 0, 8'h00);
		queue_cmd(CMD_READ, NCHAN - 1, 8'hff);
		queue_cmd(CMD_READ, 10, 8'h55);
		for (int op = CMD_READ + 1; op <= 7; op++)
			queue_cmd(CMD_W'(op), 0, 8'hff);
		queue_cmd(CMD_CLEAR, 0, 8'h00);
		queue_cmd(CMD_MEAS, 0, 8'hff);
		queue_cmd(CMD_READ, 0, 8'h00);

		// Threshold edge and a calibration run restarted by another channel.
		start_phase(MODE_THRESH, 0, 3, PACE_FULL);
		queue_cmd(CMD_SETUP, 1, 100 ^ FLIP_MASK);
		queue_cmd(CMD_MEAS, 1, 100 ^ FLIP_MASK);
		queue_cmd(CMD_MEAS, 1, 101 ^ FLIP_MASK);
		queue_cmd(CMD_CAL, 2, 8'hff);
		queue_cmd(CMD_CAL, 2, 8'hff);
		queue_cmd(CMD_CAL, 3, 10 ^ FLIP_MASK);
		queue_cmd(CMD_CAL, 3, 20 ^ FLIP_MASK);
		queue_cmd(CMD_CAL, 3, 31 ^ FLIP_MASK);
		queue_cmd(CMD_READ, 3, 8'h00);

		start_phase(MODE_ALL, 0, 1, PACE_FULL);
		queue_random_traffic(30);
		start_phase(MODE_THRESH, 20, 4, PACE_SENDER_GAPS);
		queue_random_traffic(30);
		start_phase(MODE_THRESH, 255, 2, PACE_SINK_STALLS);
		queue_random_traffic(30);
		start_phase(MODE_OFF, 7, 0, PACE_BOTH);
		queue_random_traffic(30);
		start_phase(MODE_SPARE, 100, 8, PACE_FULL);
		queue_random_traffic(30);

		// Longest run, all readings at the top so the sum reaches its largest value.
		start_phase(MODE_THRESH, 0, 255, PACE_SENDER_GAPS);
		for (int i = 0; i < 255; i++)
			queue_cmd(CMD_CAL, 9, 255 ^ FLIP_MASK);
		gen_written[9] = 1'b1;
		gen_base[9] = 255;
		queue_cmd(CMD_READ, 9, 8'h00);
		queue_random_traffic(15);

		start_phase(MODE_ALL, 50, 16, PACE_SINK_STALLS);
		queue_random_traffic(30);
		start_phase(MODE_THRESH, $urandom_range(255), $urandom_range(10, 1), PACE_BOTH);
		queue_random_traffic(30);
		start_phase(MODE_THRESH, $urandom_range(40), 3, PACE_FULL);
		queue_random_traffic(30);
		start_phase(MODE_ALL, 128, 5, PACE_SENDER_GAPS);
		queue_random_traffic(30);

		wait_drained();
		$display("%0d commands over %0d register settings; %0d results compared", accepted_count,
			phase_count, results_checked);
		$display("(%0d calibration averages, %0d measurement reports)", cal_done_count,
			report_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ channel_rssi_baseline_detector_top.f @@
design/crbd_pkg.sv
design/crbd_ram.sv
design/crbd_front.sv
design/crbd_fifo.sv
design/crbd_div.sv
design/crbd_back.sv
design/channel_rssi_baseline_detector_top.sv
test/channel_rssi_baseline_detector_top_tb.sv
